// File: hw/rtl/wbgt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbgt_pkg
// Shared widths, fixed-point constants and rounding helpers for the
// wet-bulb / WBGT datapath.
// ----------------------------------------------------------------------------
package wbgt_pkg;

  localparam int Q            = 16;
  localparam int RAD_W        = 40;
  localparam int ROOT_W       = 20;
  localparam int ROOT_STEPS   = 20;
  localparam int ARG_W        = 26;
  localparam int ATAN_W       = 20;
  localparam int CORDIC_STEPS = 24;
  localparam int XY_W         = 48;
  localparam int Z_W          = 34;
  localparam int Q16_W        = 24;

  // multiplying constants, Q24
  localparam logic signed [22:0] C_A = 23'sd2549751;
  localparam logic signed [19:0] C_B = 20'sd387570;
  localparam logic signed [17:0] C_C = 18'sd65740;
  localparam logic signed [24:0] C_W = 25'sd11744051;
  localparam logic signed [23:0] C_T = 24'sd5033165;

  // additive constants, Q16
  localparam logic signed [31:0] K_OFS1 = 32'sd544844;
  localparam logic signed [31:0] K_OFS2 = 32'sd109860;
  localparam logic signed [31:0] K_OFS3 = 32'sd307104;

  localparam logic signed [14:0] OUT_LO = -15'sd8192;
  localparam logic signed [14:0] OUT_HI = 15'sd16383;

  // atan(2^-i) in Q30
  localparam logic signed [31:0] ANGLE_TAB [CORDIC_STEPS] = '{
    32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
    32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
    32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
    32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
    32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
    32'sd1024,      32'sd512,       32'sd256,       32'sd128
  };

  // round half up, then floor shift
  function automatic logic signed [63:0] rnd64(input logic signed [63:0] v,
                                               input int unsigned s);
    logic signed [63:0] r;
    if (s == 0) begin
      r = v;
    end else begin
      r = (v + (64'sd1 <<< (s - 1))) >>> s;
    end
    return r;
  endfunction

  function automatic logic signed [14:0] round_sat(input logic signed [63:0] v,
                                                   input int unsigned s);
    logic signed [63:0] r;
    logic signed [14:0] o;
    r = rnd64(v, s);
    if (r < 64'(OUT_LO)) begin
      o = OUT_LO;
    end else if (r > 64'(OUT_HI)) begin
      o = OUT_HI;
    end else begin
      o = 15'(r);
    end
    return o;
  endfunction

endpackage

// File: hw/rtl/wbgt_sqrt_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbgt_sqrt_pipe
// Two-lane floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module wbgt_sqrt_pipe import wbgt_pkg::*; #(
  parameter int SIDE_W = 48
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [1:0][RAD_W-1:0]        rad,
  input  logic [SIDE_W-1:0]            side_in,
  output logic                         out_valid,
  output logic [1:0][ROOT_W-1:0]       root,
  output logic [SIDE_W-1:0]            side_out
);

  logic              valid_q [ROOT_STEPS];
  logic [RAD_W:0]    n_q     [ROOT_STEPS][2];
  logic [RAD_W:0]    r_q     [ROOT_STEPS][2];
  logic [SIDE_W-1:0] side_q  [ROOT_STEPS];

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    localparam logic [RAD_W:0] B = (RAD_W+1)'(1) << (2 * (ROOT_STEPS - 1 - k));
    logic              src_valid;
    logic [RAD_W:0]    src_n [2];
    logic [RAD_W:0]    src_r [2];
    logic [SIDE_W-1:0] src_side;
    logic [RAD_W:0]    n_next [2];
    logic [RAD_W:0]    r_next [2];

    if (k == 0) begin : g_first
      always_comb begin
        src_valid = in_valid;
        src_side  = side_in;
        for (int l = 0; l < 2; l++) begin
          src_n[l] = {1'b0, rad[l]};
          src_r[l] = '0;
        end
      end
    end else begin : g_rest
      always_comb begin
        src_valid = valid_q[k-1];
        src_side  = side_q[k-1];
        for (int l = 0; l < 2; l++) begin
          src_n[l] = n_q[k-1][l];
          src_r[l] = r_q[k-1][l];
        end
      end
    end

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        if (src_n[l] >= src_r[l] + B) begin
          n_next[l] = src_n[l] - (src_r[l] + B);
          r_next[l] = (src_r[l] >> 1) + B;
        end else begin
          n_next[l] = src_n[l];
          r_next[l] = src_r[l] >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k] <= 1'b0;
      end else if (en) begin
        valid_q[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[k] <= src_side;
        for (int l = 0; l < 2; l++) begin
          n_q[k][l] <= n_next[l];
          r_q[k][l] <= r_next[l];
        end
      end
    end
  end

  assign out_valid = valid_q[ROOT_STEPS-1];
  assign side_out  = side_q[ROOT_STEPS-1];
  assign root[0]   = r_q[ROOT_STEPS-1][0][ROOT_W-1:0];
  assign root[1]   = r_q[ROOT_STEPS-1][1][ROOT_W-1:0];

endmodule

// File: hw/rtl/wbgt_cordic_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbgt_cordic_pipe
// Multi-lane vectoring CORDIC arctangent, one rotation per register stage,
// with a final rounding and sign stage.
// ----------------------------------------------------------------------------
module wbgt_cordic_pipe import wbgt_pkg::*; #(
  parameter int LANES  = 4,
  parameter int SIDE_W = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [LANES-1:0][ARG_W-1:0]   arg,
  input  logic [SIDE_W-1:0]             side_in,
  output logic                          out_valid,
  output logic [LANES-1:0][ATAN_W-1:0]  atan,
  output logic [SIDE_W-1:0]             side_out
);

  logic                   valid_q [CORDIC_STEPS];
  logic signed [XY_W-1:0] x_q     [CORDIC_STEPS][LANES];
  logic signed [XY_W-1:0] y_q     [CORDIC_STEPS][LANES];
  logic signed [Z_W-1:0]  z_q     [CORDIC_STEPS][LANES];
  logic                   neg_q   [CORDIC_STEPS][LANES];
  logic [SIDE_W-1:0]      side_q  [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic                   src_valid;
    logic signed [XY_W-1:0] src_x [LANES];
    logic signed [XY_W-1:0] src_y [LANES];
    logic signed [Z_W-1:0]  src_z [LANES];
    logic                   src_neg [LANES];
    logic [SIDE_W-1:0]      src_side;

    if (i == 0) begin : g_first
      logic signed [XY_W-1:0] a_ext [LANES];
      logic signed [XY_W-1:0] a_mag [LANES];
      always_comb begin
        src_valid = in_valid;
        src_side  = side_in;
        for (int l = 0; l < LANES; l++) begin
          a_ext[l]   = XY_W'($signed(arg[l]));
          src_neg[l] = a_ext[l] < 0;
          a_mag[l]   = src_neg[l] ? -a_ext[l] : a_ext[l];
          src_x[l]   = XY_W'(64'sd1 <<< 30);
          src_y[l]   = a_mag[l] <<< 14;
          src_z[l]   = '0;
        end
      end
    end else begin : g_rest
      always_comb begin
        src_valid = valid_q[i-1];
        src_side  = side_q[i-1];
        for (int l = 0; l < LANES; l++) begin
          src_x[l]   = x_q[i-1][l];
          src_y[l]   = y_q[i-1][l];
          src_z[l]   = z_q[i-1][l];
          src_neg[l] = neg_q[i-1][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[i] <= 1'b0;
      end else if (en) begin
        valid_q[i] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[i] <= src_side;
        for (int l = 0; l < LANES; l++) begin
          neg_q[i][l] <= src_neg[l];
          if (src_y[l] >= 0) begin
            x_q[i][l] <= src_x[l] + (src_y[l] >>> i);
            y_q[i][l] <= src_y[l] - (src_x[l] >>> i);
            z_q[i][l] <= src_z[l] + Z_W'(ANGLE_TAB[i]);
          end else begin
            x_q[i][l] <= src_x[l] - (src_y[l] >>> i);
            y_q[i][l] <= src_y[l] + (src_x[l] >>> i);
            z_q[i][l] <= src_z[l] - Z_W'(ANGLE_TAB[i]);
          end
        end
      end
    end
  end

  // Q30 angle rounded to Q16, sign restored
  logic signed [Z_W-1:0] z_rnd [LANES];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      z_rnd[l] = (z_q[CORDIC_STEPS-1][l] + Z_W'(8192)) >>> 14;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= valid_q[CORDIC_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_q[CORDIC_STEPS-1];
      for (int l = 0; l < LANES; l++) begin
        atan[l] <= neg_q[CORDIC_STEPS-1][l] ? ATAN_W'(-z_rnd[l]) : ATAN_W'(z_rnd[l]);
      end
    end
  end

endmodule

// File: hw/rtl/wbgt_wet_bulb_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbgt_wet_bulb_calc
// Stull wet-bulb temperature and indoor WBGT estimate, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   The sample channel (sample_valid / sample_stall) takes one air temperature
//   and one relative humidity item, both fixed point with FRAC_BITS fraction
//   bits. Inputs are clamped to -20..50 C and 0..100 percent.
//   The result channel (result_valid / result_stall) gives the wet-bulb
//   temperature and the WBGT estimate, both saturated to -8192..16383.
//   Pipeline stages: clamp (1), two-lane square root, one bit per stage (20),
//   two product stages (2), four-lane CORDIC arctangent (25), and four stages
//   for the product terms, the sum, the WBGT blend and the output register.
//   Throughput: one item per cycle unless stalled; no item depends on another.
//   A receiver stall freezes every stage at once, so sample_stall follows
//   result_stall whenever the output register holds an item.
//   Reset (rst, synchronous) clears all valid bits; data registers keep
//   whatever they hold.
// ----------------------------------------------------------------------------
module wbgt_wet_bulb_calc import wbgt_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [14:0] air_temp,
  input  logic [14:0]        rel_humidity,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [14:0] wet_bulb_temp,
  output logic signed [14:0] wbgt_value
);

  localparam int UP_SH = Q - FRAC_BITS;
  localparam logic signed [31:0] T_LO = -(32'sd20 <<< FRAC_BITS);
  localparam logic signed [31:0] T_HI = 32'sd50 <<< FRAC_BITS;
  localparam logic signed [31:0] H_HI = 32'sd100 <<< FRAC_BITS;

  logic en;
  assign en           = !(result_valid && result_stall);
  assign sample_stall = !en;

  // clamp and scale to Q16
  logic signed [31:0]      t_ext, h_ext, t_cl, h_cl;
  logic signed [Q16_W-1:0] t16_in, h16_in;
  always_comb begin
    t_ext = 32'(air_temp);
    h_ext = {17'b0, rel_humidity};
    t_cl  = (t_ext < T_LO) ? T_LO : ((t_ext > T_HI) ? T_HI : t_ext);
    h_cl  = (h_ext > H_HI) ? H_HI : h_ext;
    t16_in = Q16_W'(t_cl <<< UP_SH);
    h16_in = Q16_W'(h_cl <<< UP_SH);
  end

  logic                    s0_valid;
  logic signed [Q16_W-1:0] s0_t16, s0_h16;
  logic [RAD_W-1:0]        s0_rad1, s0_rad2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_t16  <= t16_in;
      s0_h16  <= h16_in;
      s0_rad1 <= (RAD_W'($unsigned(h16_in)) + RAD_W'($unsigned(K_OFS1))) << Q;
      s0_rad2 <= RAD_W'($unsigned(h16_in)) << Q;
    end
  end

  // square roots
  logic                    sq_valid;
  logic [1:0][ROOT_W-1:0]  sq_root;
  logic [2*Q16_W-1:0]      sq_side;

  wbgt_sqrt_pipe #(.SIDE_W(2*Q16_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s0_valid),
    .rad       ({s0_rad2, s0_rad1}),
    .side_in   ({s0_t16, s0_h16}),
    .out_valid (sq_valid),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  logic signed [Q16_W-1:0] sq_t16, sq_h16;
  assign sq_t16 = sq_side[2*Q16_W-1:Q16_W];
  assign sq_h16 = sq_side[Q16_W-1:0];

  // first products
  logic signed [43:0] prod_a, prod_b;
  logic signed [44:0] prod_p;
  always_comb begin
    prod_a = $signed({1'b0, sq_root[0]}) * C_A;
    prod_p = sq_h16 * $signed({1'b0, sq_root[1]});
    prod_b = sq_h16 * C_B;
  end

  logic                    m1_valid;
  logic signed [Q16_W-1:0] m1_t16;
  logic signed [ARG_W-1:0] m1_arg1, m1_arg2, m1_arg3, m1_arg4;
  logic signed [31:0]      m1_p16;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_t16  <= sq_t16;
      m1_arg1 <= ARG_W'(rnd64(64'(prod_a), 24));
      m1_arg2 <= ARG_W'(sq_t16) + ARG_W'(sq_h16);
      m1_arg3 <= ARG_W'(sq_h16) - ARG_W'(K_OFS2);
      m1_arg4 <= ARG_W'(rnd64(64'(prod_b), 24));
      m1_p16  <= 32'(rnd64(64'(prod_p), Q));
    end
  end

  // humidity^1.5 times its coefficient
  logic signed [49:0] prod_c;
  assign prod_c = m1_p16 * C_C;

  logic                    m2_valid;
  logic signed [Q16_W-1:0] m2_t16, m2_pc;
  logic signed [ARG_W-1:0] m2_arg1, m2_arg2, m2_arg3, m2_arg4;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (en) begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_t16  <= m1_t16;
      m2_pc   <= Q16_W'(rnd64(64'(prod_c), 24));
      m2_arg1 <= m1_arg1;
      m2_arg2 <= m1_arg2;
      m2_arg3 <= m1_arg3;
      m2_arg4 <= m1_arg4;
    end
  end

  // arctangents
  logic                   at_valid;
  logic [3:0][ATAN_W-1:0] at_val;
  logic [2*Q16_W-1:0]     at_side;

  wbgt_cordic_pipe #(.LANES(4), .SIDE_W(2*Q16_W)) u_atan (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m2_valid),
    .arg       ({m2_arg4, m2_arg3, m2_arg2, m2_arg1}),
    .side_in   ({m2_t16, m2_pc}),
    .out_valid (at_valid),
    .atan      (at_val),
    .side_out  (at_side)
  );

  logic signed [Q16_W-1:0]  at_t16, at_pc;
  logic signed [ATAN_W-1:0] a1, a2, a3, a4;
  assign at_t16 = at_side[2*Q16_W-1:Q16_W];
  assign at_pc  = at_side[Q16_W-1:0];
  assign a1     = at_val[0];
  assign a2     = at_val[1];
  assign a3     = at_val[2];
  assign a4     = at_val[3];

  logic signed [43:0] prod_t1, prod_t4;
  always_comb begin
    prod_t1 = at_t16 * a1;
    prod_t4 = at_pc * a4;
  end

  logic                    p1_valid;
  logic signed [Q16_W-1:0] p1_t16;
  logic signed [31:0]      p1_term1, p1_term4, p1_a2, p1_a3;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= at_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_t16   <= at_t16;
      p1_term1 <= 32'(rnd64(64'(prod_t1), Q));
      p1_term4 <= 32'(rnd64(64'(prod_t4), Q));
      p1_a2    <= 32'(a2);
      p1_a3    <= 32'(a3);
    end
  end

  // wet bulb sum
  logic                    p2_valid;
  logic signed [Q16_W-1:0] p2_t16;
  logic signed [31:0]      p2_wb;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_t16 <= p1_t16;
      p2_wb  <= p1_term1 + p1_a2 - p1_a3 + p1_term4 - K_OFS3;
    end
  end

  // 0.7 wet bulb plus 0.3 air
  logic signed [56:0] prod_w;
  logic signed [47:0] prod_t;
  logic signed [63:0] blend;
  always_comb begin
    prod_w = p2_wb * C_W;
    prod_t = p2_t16 * C_T;
    blend  = 64'(prod_w) + 64'(prod_t);
  end

  logic               p3_valid;
  logic signed [31:0] p3_wb, p3_wbgt;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (en) begin
      p3_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_wb   <= p2_wb;
      p3_wbgt <= 32'(rnd64(blend, 24));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wet_bulb_temp <= round_sat(64'(p3_wb), UP_SH);
      wbgt_value    <= round_sat(64'(p3_wbgt), UP_SH);
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_wb_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (wet_bulb_temp >= OUT_LO))
    else $error("wet bulb below saturation floor");

  a_wbgt_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (wbgt_value >= OUT_LO))
    else $error("wbgt below saturation floor");

endmodule

// File: sim/wbgt_wet_bulb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbgt_wet_bulb_checker
// Watches the sample and result channels, predicts the wet-bulb and WBGT
// values of every accepted sample and compares them in order.
// ----------------------------------------------------------------------------
module wbgt_wet_bulb_checker #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  input  logic               sample_stall,
  input  logic signed [14:0] air_temp,
  input  logic [14:0]        rel_humidity,
  input  logic               result_valid,
  input  logic               result_stall,
  input  logic signed [14:0] wet_bulb_temp,
  input  logic signed [14:0] wbgt_value,
  output int                 fail_count,
  output int                 pending_count
);

  localparam int QB = 16;
  localparam longint A_CONST = 2549751;
  localparam longint B_CONST = 387570;
  localparam longint C_CONST = 65740;
  localparam longint W_CONST = 11744051;
  localparam longint T_CONST = 5033165;
  localparam longint OFS_SQRT = 544844;
  localparam longint OFS_HUM = 109860;
  localparam longint OFS_OUT = 307104;
  localparam longint LOW_LIM = -8192;
  localparam longint HIGH_LIM = 16383;

  longint rot_angle [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  typedef struct {
    logic signed [14:0] wb_temp;
    logic signed [14:0] wbgt;
  } heat_t;

  heat_t heat_q[$];

  function automatic longint round_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint floor_root(longint n);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // vectoring cordic, q16 in and out
  function automatic longint arctan_q16(longint arg);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    bit neg;
    neg = arg < 0;
    x = 64'sd1 <<< 30;
    y = (neg ? -arg : arg) * 16384;
    z = 0;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += rot_angle[i];
      end else begin
        x -= dx; y += dy; z -= rot_angle[i];
      end
    end
    z = round_shift(z, 14);
    return neg ? -z : z;
  endfunction

  function automatic logic signed [14:0] to_output(longint v16);
    longint v;
    v = round_shift(v16, QB - FRAC_BITS);
    if (v < LOW_LIM) v = LOW_LIM;
    if (v > HIGH_LIM) v = HIGH_LIM;
    return 15'(v);
  endfunction

  function automatic heat_t predict_heat(logic signed [14:0] t_in, logic [14:0] h_in);
    longint unit;
    longint t;
    longint h;
    longint t16;
    longint h16;
    longint root;
    longint term1;
    longint a2;
    longint a3;
    longint p16;
    longint a4;
    longint term4;
    longint wb;
    longint blend;
    heat_t r;
    unit = 64'sd1 <<< FRAC_BITS;
    t = t_in;
    h = h_in;
    if (t < -20 * unit) t = -20 * unit;
    if (t > 50 * unit) t = 50 * unit;
    if (h > 100 * unit) h = 100 * unit;
    t16 = t * (64'sd1 <<< (QB - FRAC_BITS));
    h16 = h * (64'sd1 <<< (QB - FRAC_BITS));
    root = floor_root((h16 + OFS_SQRT) <<< QB);
    term1 = round_shift(t16 * arctan_q16(round_shift(root * A_CONST, 24)), QB);
    a2 = arctan_q16(t16 + h16);
    a3 = arctan_q16(h16 - OFS_HUM);
    p16 = round_shift(h16 * floor_root(h16 <<< QB), QB);
    a4 = arctan_q16(round_shift(h16 * B_CONST, 24));
    term4 = round_shift(round_shift(p16 * C_CONST, 24) * a4, QB);
    wb = term1 + a2 - a3 + term4 - OFS_OUT;
    blend = round_shift(wb * W_CONST + t16 * T_CONST, 24);
    r.wb_temp = to_output(wb);
    r.wbgt = to_output(blend);
    return r;
  endfunction

  assign pending_count = heat_q.size();

  always @(posedge clk) begin
    heat_t exp_r;
    if (rst) begin
      fail_count = 0;
    end else begin
      if (sample_valid && !sample_stall) begin
        heat_q.push_back(predict_heat(air_temp, rel_humidity));
      end
      if (result_valid && !result_stall) begin
        if (heat_q.size() == 0) begin
          $display("%0t: result with none expected: wet_bulb %0d wbgt %0d",
                   $time, wet_bulb_temp, wbgt_value);
          fail_count++;
        end else begin
          exp_r = heat_q.pop_front();
          if (wet_bulb_temp !== exp_r.wb_temp) begin
            $display("%0t: wet_bulb_temp expected %0d actual %0d",
                     $time, exp_r.wb_temp, wet_bulb_temp);
            fail_count++;
          end
          if (wbgt_value !== exp_r.wbgt) begin
            $display("%0t: wbgt_value expected %0d actual %0d",
                     $time, exp_r.wbgt, wbgt_value);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// File: sim/wbgt_wet_bulb_calc_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbgt_wet_bulb_calc_tb
// Drives temperature / humidity samples with random gaps and receiver
// stalls, including one long stall that backs up the pipeline; a separate
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module wbgt_wet_bulb_calc_tb;

  logic               clk;
  logic               rst;
  logic               sample_valid;
  logic               sample_stall;
  logic signed [14:0] air_temp;
  logic [14:0]        rel_humidity;
  logic               result_valid;
  logic               result_stall;
  logic signed [14:0] wet_bulb_temp;
  logic signed [14:0] wbgt_value;
  int                 fail_count;
  int                 pending_count;
  bit                 sending_done;
  bit                 long_hold;

  wbgt_wet_bulb_calc u_dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .air_temp(air_temp), .rel_humidity(rel_humidity),
    .result_valid(result_valid), .result_stall(result_stall),
    .wet_bulb_temp(wet_bulb_temp), .wbgt_value(wbgt_value)
  );

  wbgt_wet_bulb_checker u_checker (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .air_temp(air_temp), .rel_humidity(rel_humidity),
    .result_valid(result_valid), .result_stall(result_stall),
    .wet_bulb_temp(wet_bulb_temp), .wbgt_value(wbgt_value),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = int'($urandom_range(0, 99));
    if (p < 45) return 0;
    if (p < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(5, 40));
  endfunction

  // offer one sample and wait until it is taken; valid stays up after
  task automatic send_sample(logic [14:0] t, logic [14:0] h);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    air_temp <= t;
    rel_humidity <= h;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  task automatic send_random();
    int p;
    logic [14:0] t;
    logic [14:0] h;
    p = int'($urandom_range(0, 9));
    if (p < 8) begin
      t = 15'($signed($urandom_range(0, 17920)) - 5120);
      h = 15'($urandom_range(0, 25600));
    end else begin
      t = 15'($urandom);
      h = 15'($urandom);
    end
    send_sample(t, h);
  endtask

  // receiver: random stalls, one long hold-off
  initial begin
    int n;
    bit held;
    held = 1'b0;
    result_stall = 1'b1;
    @(negedge rst);
    forever begin
      if (long_hold && !held) begin
        result_stall <= 1'b1;
        repeat (300) @(posedge clk);
        held = 1'b1;
      end
      n = gap_len();
      if (n == 0) begin
        result_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    logic [14:0] temps [8];
    logic [14:0] hums [6];
    temps = '{15'h4000, 15'h3fff, -15'sd5120, 15'sd12800,
              -15'sd5121, 15'sd12801, 15'd0, 15'sd6000};
    hums = '{15'd0, 15'd25600, 15'd25601, 15'h7fff, 15'd432, 15'd12800};
    rst = 1'b1;
    sample_valid = 1'b0;
    air_temp = '0;
    rel_humidity = '0;
    sending_done = 1'b0;
    long_hold = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < 4; i++) send_sample(temps[i], hums[i]);
    for (int i = 4; i < 8; i++) send_sample(temps[i], hums[i % 6]);
    for (int i = 0; i < 6; i++) send_sample(temps[(i + 2) % 8], hums[i]);
    send_sample(15'h5555, 15'h2aaa);
    send_sample(15'h2aaa, 15'h5555);
    for (int i = 0; i < 600; i++) send_random();
    // back up the pipeline with samples offered back to back
    long_hold = 1'b1;
    for (int i = 0; i < 100; i++) begin
      sample_valid <= 1'b1;
      air_temp <= 15'($urandom);
      rel_humidity <= 15'($urandom_range(0, 25600));
      @(posedge clk);
      while (sample_stall) @(posedge clk);
    end
    for (int i = 0; i < 530; i++) send_random();
    sample_valid <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    wait (sending_done);
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("** wbgt_wet_bulb_calc: PASSED **");
    end else begin
      $display("** wbgt_wet_bulb_calc: FAILED **");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("** wbgt_wet_bulb_calc: FAILED **");
    $finish;
  end

endmodule
